[rtl/audio_silence_trim_bounds_macros.svh]
// ---------------------------------------------------------------------------
// audio_silence_trim_bounds assertion macros
// Shared concurrent assertion forms, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef AUDIO_SILENCE_TRIM_BOUNDS_MACROS_SVH
`define AUDIO_SILENCE_TRIM_BOUNDS_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define ASTB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ASTB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASTB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ASTB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/astb_pkg.sv]
// ---------------------------------------------------------------------------
// astb_pkg
// Constants, register indexes and codes for the silence trim bound detector.
// ---------------------------------------------------------------------------
package astb_pkg;

	// parameter defaults
	localparam int SAMPLE_BITS_DEF  = 24;
	localparam int FRAME_BITS_DEF   = 24;
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int ALLOWANCE_DEF    = 4;

	// register and field widths
	localparam int THR_W   = 23;
	localparam int CHCNT_W = 4;
	localparam int MODE_W  = 2;
	localparam int CFG_W   = 23;
	localparam int IDX_W   = 2;
	localparam int OUT_W   = 24;
	localparam int STAT_W  = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_CHANNELS  = 2'd1;
	localparam logic [IDX_W-1:0] REG_MODE      = 2'd2;

	// register reset values
	localparam logic [THR_W-1:0]   THRESHOLD_RST = 23'd265;
	localparam logic [CHCNT_W-1:0] CHANNELS_RST  = 4'd1;

	// region modes
	localparam logic [MODE_W-1:0] MODE_START_ONLY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_END_ONLY   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BOTH       = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_SILENT    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_TRIM   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_TRIM      = 2'd2;

endpackage

[rtl/audio_silence_trim_bounds.sv]
// ---------------------------------------------------------------------------
// audio_silence_trim_bounds
// Finds the loud region of an interleaved audio clip and reports trim bounds.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  in      | in_valid / in_stall  | sample, last_sample
//  out     | out_valid / out_stall| trim_start, keep_end, trim_status
//  cfg     | cfg_wr_en            | cfg_index, cfg_data
//
// one sample per cycle while in_stall is low; an item is registered, then
// processed, and a last item's result is registered in the result register.
// in_stall rises only when a last item waits in the input register while the
// result register still holds an untaken result.
// arst_n clears clip state, handshake state and loads register defaults.
// ---------------------------------------------------------------------------
`include "audio_silence_trim_bounds_macros.svh"

module audio_silence_trim_bounds
	import astb_pkg::*;
#(
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int FRAME_BITS   = FRAME_BITS_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int ALLOWANCE    = ALLOWANCE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_wr_en,
	input  logic [IDX_W-1:0]              cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [OUT_W-1:0]              trim_start,
	output logic [OUT_W-1:0]              keep_end,
	output logic [STAT_W-1:0]             trim_status
);

	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
	localparam int EXT_W = FRAME_BITS + 9;
	localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

	// configuration registers
	logic [THR_W-1:0]   threshold_q;
	logic [CHCNT_W-1:0] chan_count_q;
	logic [MODE_W-1:0]  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RST;
			chan_count_q <= CHANNELS_RST;
			mode_q       <= MODE_BOTH;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q  <= cfg_data[THR_W-1:0];
				REG_CHANNELS:  chan_count_q <= cfg_data[CHCNT_W-1:0];
				REG_MODE:      mode_q       <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          last_s1;
	logic                          advance;
	logic                          in_take;
	logic                          out_take;
	logic                          out_valid_q;

	assign out_take = out_valid_q && !out_stall;
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= sample;
			last_s1   <= last_sample;
		end
	end

	// clip state
	logic [FRAME_BITS-1:0] frame_q;
	logic [CH_W-1:0]       chan_q;
	logic                  frame_loud_q;
	logic                  seen_q;
	logic [FRAME_BITS-1:0] first_q;
	logic [FRAME_BITS-1:0] lend_q;

	// magnitude and loudness
	logic [SAMPLE_BITS-1:0] raw;
	logic [SAMPLE_BITS-1:0] mag;
	logic                   loud;

	assign raw  = sample_s1;
	assign mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
	assign loud = CMP_W'(mag) > CMP_W'(threshold_q);

	// frame close decision
	logic [CNT_W-1:0] eff_chan;
	logic [CH_W:0]    chan_plus;
	logic             close;
	logic             loud_now;

	always_comb begin
		if (chan_count_q == '0) begin
			eff_chan = CNT_W'(1);
		end else if (5'(chan_count_q) > 5'(MAX_CHANNELS)) begin
			eff_chan = CNT_W'(MAX_CHANNELS);
		end else begin
			eff_chan = CNT_W'(chan_count_q);
		end
	end

	assign chan_plus = {1'b0, chan_q} + 1'b1;
	assign close     = (6'(chan_plus) >= 6'(eff_chan)) || last_s1;
	assign loud_now  = frame_loud_q || loud;

	// next clip state
	logic [FRAME_BITS-1:0] frame_inc;
	logic [FRAME_BITS-1:0] frame_nx;
	logic [CH_W-1:0]       chan_nx;
	logic                  frame_loud_nx;
	logic                  seen_nx;
	logic [FRAME_BITS-1:0] first_nx;
	logic [FRAME_BITS-1:0] lend_nx;

	assign frame_inc = (frame_q != FRAME_MAX) ? frame_q + 1'b1 : frame_q;

	always_comb begin
		frame_nx      = frame_q;
		chan_nx       = chan_q;
		frame_loud_nx = loud_now;
		seen_nx       = seen_q;
		first_nx      = first_q;
		lend_nx       = lend_q;
		if (close) begin
			if (loud_now) begin
				if (!seen_q) begin
					first_nx = frame_q;
				end
				lend_nx = frame_inc;
				seen_nx = 1'b1;
			end
			frame_nx      = frame_inc;
			chan_nx       = '0;
			frame_loud_nx = 1'b0;
		end else begin
			chan_nx = CH_W'(chan_plus);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q      <= '0;
			chan_q       <= '0;
			frame_loud_q <= 1'b0;
			seen_q       <= 1'b0;
			first_q      <= '0;
			lend_q       <= '0;
		end else if (advance) begin
			if (last_s1) begin
				frame_q      <= '0;
				chan_q       <= '0;
				frame_loud_q <= 1'b0;
				seen_q       <= 1'b0;
				first_q      <= '0;
				lend_q       <= '0;
			end else begin
				frame_q      <= frame_nx;
				chan_q       <= chan_nx;
				frame_loud_q <= frame_loud_nx;
				seen_q       <= seen_nx;
				first_q      <= first_nx;
				lend_q       <= lend_nx;
			end
		end
	end

	// bounds
	logic             do_start;
	logic             do_end;
	logic [EXT_W-1:0] total_ext;
	logic [EXT_W-1:0] first_ext;
	logic [EXT_W-1:0] end_ext;
	logic [EXT_W-1:0] tstart;
	logic [EXT_W-1:0] kend;
	logic [STAT_W-1:0] status;

	assign do_start  = (mode_q != MODE_END_ONLY);
	assign do_end    = (mode_q != MODE_START_ONLY);
	assign total_ext = EXT_W'(frame_nx);
	assign first_ext = EXT_W'(first_nx);
	assign end_ext   = EXT_W'(lend_nx) + EXT_W'(ALLOWANCE);

	always_comb begin
		tstart = '0;
		kend   = total_ext;
		status = STAT_SILENT;
		if (seen_nx) begin
			if (do_start && (first_ext >= EXT_W'(ALLOWANCE))) begin
				tstart = first_ext - EXT_W'(ALLOWANCE);
			end
			if (do_end && (end_ext < total_ext)) begin
				kend = end_ext;
			end
			status = ((tstart == '0) && (kend == total_ext)) ? STAT_NO_TRIM : STAT_TRIM;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [OUT_W-1:0]  trim_start_q;
	logic [OUT_W-1:0]  keep_end_q;
	logic [STAT_W-1:0] status_q;

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			trim_start_q <= OUT_W'(tstart);
			keep_end_q   <= OUT_W'(kend);
			status_q     <= status;
		end
	end

	assign out_valid   = out_valid_q;
	assign trim_start  = trim_start_q;
	assign keep_end    = keep_end_q;
	assign trim_status = status_q;

	// checks
	`ASTB_ASSERT_NXT(a_last_gives_result, clk, arst_n, advance && last_s1, out_valid_q, "last item produced no result")
	`ASTB_ASSERT_NXT(a_clip_cleared, clk, arst_n, advance && last_s1, (frame_q == '0) && !seen_q && (chan_q == '0), "clip state not cleared after last item")
	`ASTB_ASSERT_IMP(a_stall_needs_item, clk, arst_n, in_stall, valid_s1 && last_s1 && out_valid_q, "input stalled without a pending last item")
	`ASTB_ASSERT_IMP(a_bounds_order, clk, arst_n, seen_q, (first_q < lend_q) && (lend_q <= frame_q), "loud bounds out of order")

endmodule
